/* hw/rtl/cir_pkg.sv */
package cir_pkg;

    localparam int BUF_BYTES  = 115200;
    localparam int MAX_PIECES = 64;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int TOT_W  = 7;
    localparam int NUM_W  = 7;
    localparam int BYTE_W = 8;
    localparam int RA_W   = 17;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // derived widths
    localparam int ADDR_W  = $clog2(BUF_BYTES);
    localparam int WP_W    = $clog2(BUF_BYTES + 1);
    localparam int PIECE_W = WP_W;
    localparam int DIVD_W  = $clog2(BUF_BYTES + MAX_PIECES);
    localparam int PROD_W  = NUM_W + PIECE_W;
    localparam int PN_W    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_BEGIN = 2'd0,
        FN_BYTE  = 2'd1,
        FN_END   = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_BEGIN_OK  = 3'd0,
        ST_BEGIN_REF = 3'd1,
        ST_STORED    = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_COMPLETE  = 3'd4,
        ST_INCOMPL   = 3'd5,
        ST_READ_DATA = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_OPEN = 2'd2,
        S_READ = 2'd3
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  read_data;
        logic [CNT_W-1:0]   received;
        logic [CNT_W-1:0]   expected;
        logic               ready;
    } t_result;

endpackage

/* hw/rtl/cir_ram.sv */
module cir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cir_div.sv */
module cir_div
    import cir_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [TOT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [TOT_W-1:0]  r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [TOT_W-1:0]  r_div;

    logic [TOT_W:0]    w_shift;
    logic              w_fit;
    logic [TOT_W:0]    w_diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_shift = {r_rem, r_quo[DIVD_W-1]};
        w_fit   = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[TOT_W-1:0] : w_shift[TOT_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/chunked_image_reassembly.sv */
// Rebuilds an image buffer from numbered chunks, one byte per item, with one result item for
// every input item. Bytes of a chunk already open stream at one byte a cycle while the output
// side keeps up; the first byte of a chunk goes through the open state (the chunk offset is
// multiplied out, then range-checked), and a read waits for the registered read of the image
// RAM. An accepted begin waits while the bit-serial divider works out the chunk size. The image
// store sits in a single-port-write, single-port-read RAM and holds no defined contents until
// written.
module chunked_image_reassembly
    import cir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // chunk_total[6:0], chunk_number[13:7], data_byte[21:14], read_address[38:22], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]      i_s_tuser,
    // last_byte
    input  logic                   i_s_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // read_data[7:0], received_chunks[14:8], expected_chunks_out[21:15], image_ready[22], pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // status[2:0]
    output logic [STAT_W-1:0]      o_m_tuser
);

    t_state r_state, n_state;

    logic [MAX_PIECES-1:0] r_seen, n_seen;
    logic [CNT_W-1:0]      r_received, n_received;
    logic [CNT_W-1:0]      r_expected, n_expected;
    logic [PIECE_W-1:0]    r_piece, n_piece;
    logic                  r_in_chunk, n_in_chunk;
    logic                  r_keep, n_keep;
    logic [WP_W-1:0]       r_wp, n_wp;
    logic [PN_W-1:0]       r_cur, n_cur;
    logic                  r_out_valid;
    t_result               r_out, n_res;
    logic                  res_load;

    // held first byte of a chunk and read flag
    logic [NUM_W-1:0]      r_num;
    logic [BYTE_W-1:0]     r_data;
    logic                  r_last;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_rd_ok;

    logic                  accept;
    t_func                 in_func;
    logic [TOT_W-1:0]      in_tot;
    logic [NUM_W-1:0]      in_num;
    logic [BYTE_W-1:0]     in_data;
    logic [RA_W-1:0]       in_addr;
    logic                  tot_ok;
    logic [PROD_W-1:0]     w_prod;
    logic                  open_ok;

    logic                  byte_go;
    logic                  byte_keep;
    logic [WP_W-1:0]       byte_wp;
    logic [BYTE_W-1:0]     byte_data;
    logic                  byte_last;
    logic [PN_W-1:0]       byte_idx;

    logic                  ram_we;
    logic [BYTE_W-1:0]     ram_q;
    logic                  div_start;
    logic                  div_done;
    logic [DIVD_W-1:0]     div_q;

    assign in_func = t_func'(i_s_tuser);
    assign in_tot  = i_s_tdata[6:0];
    assign in_num  = i_s_tdata[13:7];
    assign in_data = i_s_tdata[21:14];
    assign in_addr = i_s_tdata[38:22];

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    assign tot_ok  = (in_tot != '0) && (in_tot <= TOT_W'(MAX_PIECES));
    assign w_prod  = PROD_W'(in_num) * PROD_W'(r_piece);
    assign open_ok = (r_expected != '0) && (CNT_W'(r_num) < r_expected)
                     && !r_seen[r_num[PN_W-1:0]] && (r_prod < PROD_W'(BUF_BYTES));

    assign div_start = accept && (in_func == FN_BEGIN) && tot_ok;

    cir_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIVD_W'(BUF_BYTES - 1) + DIVD_W'(in_tot)),
        .i_divisor  (in_tot),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    cir_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (byte_wp[ADDR_W-1:0]),
        .i_wdata (byte_data),
        .i_raddr (in_addr[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_func)
                        FN_BEGIN: n_state = tot_ok ? S_DIV : S_IDLE;
                        FN_BYTE:  n_state = r_in_chunk ? S_IDLE : S_OPEN;
                        FN_END:   n_state = S_IDLE;
                        FN_READ:  n_state = S_READ;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:   n_state = div_done ? S_IDLE : S_DIV;
            S_OPEN:  n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // byte path shared by an open chunk and by the first byte of a new one
    always_comb begin
        byte_go   = 1'b0;
        byte_keep = r_keep;
        byte_wp   = r_wp;
        byte_data = in_data;
        byte_last = i_s_tlast;
        byte_idx  = r_cur;
        if (r_state == S_OPEN) begin
            byte_go   = 1'b1;
            byte_keep = open_ok;
            byte_wp   = open_ok ? r_prod[WP_W-1:0] : '0;
            byte_data = r_data;
            byte_last = r_last;
            byte_idx  = r_num[PN_W-1:0];
        end else if (accept && (in_func == FN_BYTE) && r_in_chunk) begin
            byte_go = 1'b1;
        end
    end

    always_comb begin
        n_seen     = r_seen;
        n_received = r_received;
        n_expected = r_expected;
        n_piece    = r_piece;
        n_in_chunk = r_in_chunk;
        n_keep     = r_keep;
        n_wp       = r_wp;
        n_cur      = r_cur;
        ram_we     = 1'b0;
        res_load   = 1'b0;
        n_res      = '{status: ST_DROPPED, read_data: '0, received: r_received,
                       expected: r_expected, ready: 1'b0};

        if (byte_go) begin
            res_load   = 1'b1;
            n_wp       = byte_wp;
            n_cur      = byte_idx;
            n_in_chunk = !byte_last;
            n_keep     = byte_keep && !byte_last;
            if (byte_keep) begin
                if (byte_wp < WP_W'(BUF_BYTES)) begin
                    ram_we       = 1'b1;
                    n_wp         = WP_W'(byte_wp + 1'b1);
                    n_res.status = ST_STORED;
                end
                if (byte_last) begin
                    n_seen[byte_idx] = 1'b1;
                    n_received       = CNT_W'(r_received + 1'b1);
                end
            end
            n_res.received = n_received;
        end else if (accept) begin
            case (in_func)
                FN_BEGIN: begin
                    if (tot_ok) begin
                        n_seen     = '0;
                        n_received = '0;
                        n_expected = in_tot;
                        n_in_chunk = 1'b0;
                        n_keep     = 1'b0;
                        n_wp       = '0;
                    end else begin
                        res_load     = 1'b1;
                        n_res.status = ST_BEGIN_REF;
                    end
                end
                FN_END: begin
                    res_load   = 1'b1;
                    n_expected = '0;
                    n_in_chunk = 1'b0;
                    n_keep     = 1'b0;
                    if ((r_expected != '0) && (r_received >= r_expected)) begin
                        n_res.status = ST_COMPLETE;
                        n_res.ready  = 1'b1;
                    end else begin
                        n_res.status = ST_INCOMPL;
                    end
                    n_res.expected = '0;
                end
                default: begin
                end
            endcase
        end else if ((r_state == S_DIV) && div_done) begin
            res_load     = 1'b1;
            n_piece      = div_q[PIECE_W-1:0];
            n_res.status = ST_BEGIN_OK;
        end else if (r_state == S_READ) begin
            res_load        = 1'b1;
            n_res.status    = ST_READ_DATA;
            n_res.read_data = r_rd_ok ? ram_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_received  <= '0;
            r_expected  <= '0;
            r_piece     <= '0;
            r_in_chunk  <= 1'b0;
            r_keep      <= 1'b0;
            r_wp        <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seen     <= n_seen;
            r_received <= n_received;
            r_expected <= n_expected;
            r_piece    <= n_piece;
            r_in_chunk <= n_in_chunk;
            r_keep     <= n_keep;
            r_wp       <= n_wp;
            r_cur      <= n_cur;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= n_res;
        end
        if (accept) begin
            r_num   <= in_num;
            r_data  <= in_data;
            r_last  <= i_s_tlast;
            r_prod  <= w_prod;
            r_rd_ok <= (RA_W + 1)'(in_addr) < (RA_W + 1)'(BUF_BYTES);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = OUT_TDATA_W'({r_out.ready, r_out.expected, r_out.received,
                                      r_out.read_data});

endmodule

/* tb/sv/chunked_image_reassembly_test.sv */
module chunked_image_reassembly_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cir_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 40;

    // Mirror of the reassembly state; one expected result per accepted item.
    class reassembly_scoreboard;
        logic [BYTE_W-1:0]  image_mem [BUF_BYTES];
        bit                 was_written [BUF_BYTES];
        int unsigned        written_addrs [$];
        logic [MAX_PIECES-1:0] seen_chunks;
        int unsigned        rcv_cnt;
        int unsigned        exp_cnt;
        int unsigned        piece_len;
        int unsigned        wr_ptr;
        int unsigned        cur_num;
        bit                 in_chunk;
        bit                 keep_chunk;
        t_result            pending [$];
        int                 errors;

        function void note_item(t_func fn, int unsigned total, int unsigned num,
                                logic [BYTE_W-1:0] data, logic last, int unsigned addr);
            t_result r;
            bit      complete;
            r = '0;
            case (fn)
                FN_BEGIN: begin
                    if (total < 1 || total > MAX_PIECES) begin
                        r.status = ST_BEGIN_REF;
                    end else begin
                        seen_chunks = '0;
                        rcv_cnt     = 0;
                        exp_cnt     = total;
                        piece_len   = (BUF_BYTES + total - 1) / total;
                        in_chunk    = 0;
                        keep_chunk  = 0;
                        wr_ptr      = 0;
                        r.status    = ST_BEGIN_OK;
                    end
                end
                FN_BYTE: begin
                    // the first byte decides the fate of the whole chunk
                    if (!in_chunk) begin
                        keep_chunk = 0;
                        if (exp_cnt > 0 && num < exp_cnt && num < MAX_PIECES) begin
                            if (!seen_chunks[num[PN_W-1:0]] && num * piece_len < BUF_BYTES)
                                keep_chunk = 1;
                        end
                        in_chunk = 1;
                        wr_ptr   = keep_chunk ? num * piece_len : 0;
                        cur_num  = num;
                    end
                    r.status = ST_DROPPED;
                    if (keep_chunk) begin
                        if (wr_ptr < BUF_BYTES) begin
                            image_mem[wr_ptr[ADDR_W-1:0]] = data;
                            if (!was_written[wr_ptr[ADDR_W-1:0]]) begin
                                was_written[wr_ptr[ADDR_W-1:0]] = 1;
                                written_addrs.push_back(wr_ptr);
                            end
                            wr_ptr++;
                            r.status = ST_STORED;
                        end
                        if (last) begin
                            seen_chunks[cur_num[PN_W-1:0]] = 1'b1;
                            rcv_cnt++;
                        end
                    end
                    if (last) begin
                        in_chunk   = 0;
                        keep_chunk = 0;
                    end
                end
                FN_END: begin
                    complete   = exp_cnt > 0 && rcv_cnt >= exp_cnt;
                    r.status   = complete ? ST_COMPLETE : ST_INCOMPL;
                    r.ready    = complete;
                    exp_cnt    = 0;
                    in_chunk   = 0;
                    keep_chunk = 0;
                end
                default: begin
                    r.status = ST_READ_DATA;
                    if (addr < BUF_BYTES)
                        r.read_data = image_mem[addr[ADDR_W-1:0]];
                end
            endcase
            r.received = rcv_cnt[CNT_W-1:0];
            r.expected = exp_cnt[CNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
            compare_field("received_chunks", 32'(want.received), 32'(got.received));
            compare_field("expected_chunks_out", 32'(want.expected), 32'(got.expected));
            compare_field("image_ready", 32'(want.ready), 32'(got.ready));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [FUNC_W-1:0]      i_s_tuser;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [STAT_W-1:0]      o_m_tuser;

    reassembly_scoreboard sb = new;
    bit          no_gaps;
    int unsigned sent_items;

    chunked_image_reassembly u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_m_tready = no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_result out_item;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            out_item.status    = t_status'(o_m_tuser);
            out_item.read_data = o_m_tdata[7:0];
            out_item.received  = o_m_tdata[14:8];
            out_item.expected  = o_m_tdata[21:15];
            out_item.ready     = o_m_tdata[22];
            sb.check_result(out_item);
        end
    end

    task automatic send(t_func fn, logic [TOT_W-1:0] total, logic [NUM_W-1:0] num,
                        logic [BYTE_W-1:0] data, logic last, logic [RA_W-1:0] addr);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = fn;
        i_s_tlast  = last;
        i_s_tdata  = {1'b0, addr, data, num, total};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_item(fn, 32'(total), 32'(num), data, last, 32'(addr));
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_begin(int unsigned total);
        send(FN_BEGIN, TOT_W'(total), NUM_W'($urandom_range(0, 127)),
             BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             RA_W'($urandom_range(0, (1 << RA_W) - 1)));
    endtask

    task automatic send_end();
        send(FN_END, TOT_W'($urandom_range(0, 127)), NUM_W'($urandom_range(0, 127)),
             BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             RA_W'($urandom_range(0, (1 << RA_W) - 1)));
    endtask

    task automatic send_read(int unsigned addr);
        send(FN_READ, TOT_W'($urandom_range(0, 127)), NUM_W'($urandom_range(0, 127)),
             BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), RA_W'(addr));
    endtask

    task automatic send_byte(int unsigned num, int unsigned data, bit last);
        send(FN_BYTE, TOT_W'($urandom_range(0, 127)), NUM_W'(num), BYTE_W'(data), last,
             RA_W'($urandom_range(0, (1 << RA_W) - 1)));
    endtask

    // later bytes carry a random chunk number, which the block must ignore
    task automatic send_chunk(int unsigned num, int unsigned len, bit close);
        int unsigned j;
        for (j = 0; j < len; j++)
            send_byte((j == 0) ? num : $urandom_range(0, 127), $urandom_range(0, 255),
                      close && (j == len - 1));
    endtask

    // read only what has been written, or past the buffer end
    function automatic int unsigned read_target();
        if (sb.written_addrs.size() == 0 || $urandom_range(0, 3) == 0)
            return $urandom_range(BUF_BYTES, (1 << RA_W) - 1);
        return sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)];
    endfunction

    task automatic send_noise();
        t_func fn;
        fn = t_func'($urandom_range(0, 3));
        case (fn)
            FN_BEGIN: send_begin($urandom_range(0, 127));
            FN_BYTE:  send_byte($urandom_range(0, 127), $urandom_range(0, 255),
                                1'($urandom_range(0, 1)));
            FN_END:   send_end();
            default:  send_read(read_target());
        endcase
    endtask

    task automatic run_transfer();
        int unsigned total;
        int unsigned r;
        int unsigned k;
        int unsigned j;
        int unsigned tmp;
        int unsigned len;
        int unsigned pick;
        int unsigned order [MAX_PIECES];
        bit          skip_one;
        r = $urandom_range(0, 9);
        total = (r < 6) ? $urandom_range(1, 6) :
                (r < 9) ? $urandom_range(7, 40) : MAX_PIECES;
        for (k = 0; k < total; k++)
            order[k[PN_W-1:0]] = k;
        for (k = total - 1; k > 0; k--) begin
            j                  = $urandom_range(0, k);
            tmp                = order[k[PN_W-1:0]];
            order[k[PN_W-1:0]] = order[j[PN_W-1:0]];
            order[j[PN_W-1:0]] = tmp;
        end
        skip_one = ($urandom_range(0, 3) == 0);
        send_begin(total);
        for (k = 32'(skip_one); k < total; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_read(read_target());
            end else if (pick == 1 && k > 0) begin
                j = $urandom_range(0, k - 1);
                send_chunk(order[j[PN_W-1:0]], $urandom_range(1, 3), 1'b1);
            end else if (pick == 2) begin
                send_chunk($urandom_range(total, 127), $urandom_range(1, 3), 1'b1);
            end else if (pick == 3) begin
                send_begin($urandom_range(0, 1) ? 0 : $urandom_range(MAX_PIECES + 1, 127));
            end
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            if ($urandom_range(0, 39) == 0) begin
                // break off mid-chunk, then close or restart the transfer
                send_chunk(order[k[PN_W-1:0]], len, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_end();
                    return;
                end
                send_begin(total);
            end else begin
                send_chunk(order[k[PN_W-1:0]], len, 1'b1);
            end
        end
        send_end();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = FN_BEGIN;
        i_s_tlast  = 1'b0;
        no_gaps    = 1'b0;
        sent_items = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_end();
        send_byte(3, 8'h00, 1'b1);
        send_begin(0);
        send_begin(127);
        send_begin(MAX_PIECES + 1);
        send_begin(MAX_PIECES);
        send_byte(0, 8'hFF, 1'b1);
        send_byte(MAX_PIECES - 1, 8'h00, 1'b1);
        send_byte(0, 8'h55, 1'b1);
        send_byte(MAX_PIECES, 8'hAA, 1'b1);
        send_byte(127, 8'hAA, 1'b1);
        send_byte(5, 8'h11, 1'b0);
        send_byte(127, 8'h22, 1'b1);
        send_byte(7, 8'h33, 1'b0);
        send_begin(1);
        send_byte(0, 8'hA5, 1'b1);
        send_end();
        send_begin(2);
        send_byte(1, 8'h5A, 1'b0);
        send_end();
        send_read(0);
        send_read(BUF_BYTES / MAX_PIECES * (MAX_PIECES - 1));
        send_read(BUF_BYTES / 2);
        send_read((1 << RA_W) - 1);
        send_read(BUF_BYTES);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            no_gaps = (sent_items >= 350 && sent_items < 600);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) send_noise();
            else
                run_transfer();
        end
        no_gaps = 1'b0;

        i_s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
